### rtl/core/crbt_pkg.sv
// Package for the coverage region bitmap tracker: payload structs, codes,
// sizes and the queue entry between the front and back parts. No dependencies.
`timescale 1ns / 1ps
package crbt_pkg;

    localparam int MAX_REGIONS = 16;
    localparam int SLOT_W      = 4;
    localparam int BITMAP_BITS = 16384;
    localparam int OFF_W       = 14;
    localparam int WORD_OFF_W  = OFF_W - 5;
    localparam int MEM_AW      = SLOT_W + WORD_OFF_W;
    localparam int MEM_DEPTH   = 1 << MEM_AW;
    localparam int CNT_W       = 32;
    localparam int RCNT_W      = 5;
    localparam int Q_DEPTH     = 2;

    typedef enum logic [1:0] {
        FN_LOAD   = 2'd0,
        FN_HIT    = 2'd1,
        FN_FINISH = 2'd2,
        FN_NONE   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ZERO    = 2'd1,
        ST_OUTSIDE = 2'd2,
        ST_BEYOND  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_RUN,
        BK_READ,
        BK_WRITE
    } back_state_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [3:0]  slot;
        logic [63:0] region_start;
        logic [63:0] region_end;
        logic [63:0] region_base;
        logic [63:0] block_address;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  done_func;
        logic [1:0]  status;
        logic [3:0]  found_slot;
        logic        is_new;
        logic [31:0] hit_count;
        logic [31:0] total_count;
        logic [31:0] new_count;
        logic [4:0]  region_count;
        logic [4:0]  covered_region_count;
    } out_item_t;

    // Classified item handed from the front part to the back part.
    typedef struct packed {
        func_t               func;
        status_t             status;
        logic [SLOT_W-1:0]   slot;
        logic [OFF_W-1:0]    offset;
        logic [CNT_W-1:0]    hit_count;
        logic [CNT_W-1:0]    total_count;
        logic [RCNT_W-1:0]   region_count;
        logic [RCNT_W-1:0]   covered_region_count;
    } job_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        sat_inc = (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
    endfunction

endpackage

### rtl/core/crbt_front.sv
// Front part: region table, two-stage classification of hits, run counters.
// Depends on crbt_pkg.
`timescale 1ns / 1ps
module crbt_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  crbt_pkg::in_item_t in_data,
    input  logic               in_valid,
    output logic               in_ready,
    output crbt_pkg::job_t     job,
    output logic               job_valid,
    input  logic               job_ready
);

    logic [63:0] start_reg [crbt_pkg::MAX_REGIONS];
    logic [63:0] end_reg   [crbt_pkg::MAX_REGIONS];
    logic [63:0] base_reg  [crbt_pkg::MAX_REGIONS];
    logic [crbt_pkg::MAX_REGIONS-1:0] valid_reg, valid_next;
    logic [crbt_pkg::MAX_REGIONS-1:0] touched_reg, touched_next;
    logic [crbt_pkg::CNT_W-1:0] nz_reg, nz_next, all_reg, all_next;

    // Stage 1: found flag and selected slot, registered.
    logic                       s1_valid_reg;
    crbt_pkg::in_item_t         s1_item_reg;
    logic                       s1_found_reg;
    logic [crbt_pkg::SLOT_W-1:0] s1_best_reg;

    logic                        best_found;
    logic [crbt_pkg::SLOT_W-1:0] best_idx;
    logic                        s1_take, s1_move;

    // Selection tree: leaves sit at MAX_REGIONS + slot, node n has children 2n and 2n+1.
    logic                        nd_found [2*crbt_pkg::MAX_REGIONS];
    logic [63:0]                 nd_start [2*crbt_pkg::MAX_REGIONS];
    logic [crbt_pkg::SLOT_W-1:0] nd_idx   [2*crbt_pkg::MAX_REGIONS];

    always_comb
    begin
        for (int i = 0; i < 2*crbt_pkg::MAX_REGIONS; i++)
        begin
            nd_found[i] = 1'b0;
            nd_start[i] = '0;
            nd_idx[i]   = '0;
        end
        for (int i = 0; i < crbt_pkg::MAX_REGIONS; i++)
        begin
            nd_found[crbt_pkg::MAX_REGIONS+i] =
                valid_reg[i] && (start_reg[i] <= in_data.block_address);
            nd_start[crbt_pkg::MAX_REGIONS+i] = start_reg[i];
            nd_idx[crbt_pkg::MAX_REGIONS+i]   = crbt_pkg::SLOT_W'(i);
        end
        // The left child holds the lower slots, so it keeps equal starts.
        for (int n = crbt_pkg::MAX_REGIONS - 1; n >= 1; n--)
        begin
            if (nd_found[2*n+1] && (!nd_found[2*n] || nd_start[2*n+1] > nd_start[2*n]))
            begin
                nd_found[n] = 1'b1;
                nd_start[n] = nd_start[2*n+1];
                nd_idx[n]   = nd_idx[2*n+1];
            end
            else
            begin
                nd_found[n] = nd_found[2*n];
                nd_start[n] = nd_start[2*n];
                nd_idx[n]   = nd_idx[2*n];
            end
        end
        best_found = nd_found[1];
        best_idx   = nd_idx[1];
    end

    // Stage 1 holds one item; a stalled queue holds stage 1.
    assign s1_move  = s1_valid_reg && job_ready;
    assign in_ready = !s1_valid_reg;
    assign s1_take  = in_valid && in_ready;
    assign job_valid = s1_valid_reg;

    // Stage 2 work (table state update and job form) happens when s1 leaves.
    logic [63:0] off_full;
    logic        covered;
    always_comb
    begin
        off_full = s1_item_reg.block_address - base_reg[s1_best_reg];
        covered  = s1_found_reg && (s1_item_reg.block_address < end_reg[s1_best_reg]);
        job              = '0;
        job.func         = crbt_pkg::func_t'(s1_item_reg.func);
        job.status       = crbt_pkg::ST_OK;
        valid_next       = valid_reg;
        touched_next     = touched_reg;
        nz_next          = nz_reg;
        all_next         = all_reg;
        case (crbt_pkg::func_t'(s1_item_reg.func))
            crbt_pkg::FN_LOAD:
            begin
                valid_next[s1_item_reg.slot]   = 1'b1;
                touched_next[s1_item_reg.slot] = 1'b0;
            end
            crbt_pkg::FN_HIT:
            begin
                all_next = crbt_pkg::sat_inc(all_reg);
                if (s1_item_reg.block_address == '0)
                    job.status = crbt_pkg::ST_ZERO;
                else
                begin
                    nz_next = crbt_pkg::sat_inc(nz_reg);
                    if (!covered)
                        job.status = crbt_pkg::ST_OUTSIDE;
                    else
                    begin
                        touched_next[s1_best_reg] = 1'b1;
                        job.slot   = s1_best_reg;
                        job.offset = off_full[crbt_pkg::OFF_W-1:0];
                        if (off_full[63:crbt_pkg::OFF_W] != '0)
                            job.status = crbt_pkg::ST_BEYOND;
                    end
                end
            end
            crbt_pkg::FN_FINISH:
            begin
                job.hit_count   = nz_reg;
                job.total_count = all_reg;
                job.region_count = crbt_pkg::RCNT_W'($countones(valid_reg));
                job.covered_region_count =
                    crbt_pkg::RCNT_W'($countones(valid_reg & touched_reg));
                valid_next   = '0;
                touched_next = '0;
                nz_next      = '0;
                all_next     = '0;
            end
            default:
            begin
                job.func = crbt_pkg::FN_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            valid_reg    <= '0;
            touched_reg  <= '0;
            nz_reg       <= '0;
            all_reg      <= '0;
        end
        else
        begin
            if (s1_take)
                s1_valid_reg <= 1'b1;
            else if (s1_move)
                s1_valid_reg <= 1'b0;
            if (s1_move)
            begin
                valid_reg   <= valid_next;
                touched_reg <= touched_next;
                nz_reg      <= nz_next;
                all_reg     <= all_next;
            end
        end
    end

    // A load only changes the table after it has left stage 1, and a hit in
    // stage 1 was compared against the old table, so a load followed by a hit
    // must not overlap: stage 1 is blocked while it holds an item anyway,
    // so the compare for the next item always sees the updated table.
    always_ff @(posedge clk)
    begin
        if (s1_take)
        begin
            s1_item_reg  <= in_data;
            s1_found_reg <= best_found;
            s1_best_reg  <= best_idx;
        end
        if (s1_move && crbt_pkg::func_t'(s1_item_reg.func) == crbt_pkg::FN_LOAD)
        begin
            start_reg[s1_item_reg.slot] <= s1_item_reg.region_start;
            end_reg[s1_item_reg.slot]   <= s1_item_reg.region_end;
            base_reg[s1_item_reg.slot]  <= s1_item_reg.region_base;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (touched_reg & ~valid_reg) == '0)
        else $error("touched region that is not valid");
    assert property (@(posedge clk) disable iff (!rst_n)
        nz_reg <= all_reg)
        else $error("nonzero hits exceed all hits");
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !job_ready |=> s1_valid_reg && $stable(s1_item_reg))
        else $error("stage 1 lost a stalled item");

endmodule

### rtl/core/crbt_back.sv
// Back part: two-entry queue, persistent bitmap memory with read-modify-write,
// new-bit counter and output register. Depends on crbt_pkg.
`timescale 1ns / 1ps
module crbt_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  crbt_pkg::job_t      job,
    input  logic                job_valid,
    output logic                job_ready,
    output crbt_pkg::out_item_t out_data,
    output logic                out_valid,
    input  logic                out_ready
);

    crbt_pkg::job_t q_reg [crbt_pkg::Q_DEPTH];
    logic           wp_reg, rp_reg;
    logic [1:0]     cnt_reg;

    logic [31:0] mem [crbt_pkg::MEM_DEPTH];
    logic [31:0] rd_reg;

    crbt_pkg::back_state_t state_reg, state_next;
    logic [crbt_pkg::MEM_AW-1:0] clr_reg;
    logic [crbt_pkg::CNT_W-1:0]  newc_reg;
    logic                        ov_reg;
    crbt_pkg::out_item_t         od_reg;

    crbt_pkg::job_t head;
    logic           push, pop, rd_en, wr_en, emit;
    logic [crbt_pkg::MEM_AW-1:0] addr;
    logic [31:0] bitm, wdata;
    crbt_pkg::out_item_t res;

    assign head      = q_reg[rp_reg];
    assign job_ready = (cnt_reg != 2'd2);
    assign push      = job_valid && job_ready;
    assign addr      = {head.slot, head.offset[crbt_pkg::OFF_W-1:5]};
    assign bitm      = 32'd1 << head.offset[4:0];
    assign out_data  = od_reg;
    assign out_valid = ov_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            crbt_pkg::BK_CLEAR:
                if (clr_reg == {crbt_pkg::MEM_AW{1'b1}})
                    state_next = crbt_pkg::BK_RUN;
            crbt_pkg::BK_RUN:
                if (cnt_reg != '0 && (!ov_reg || out_ready) &&
                    head.func == crbt_pkg::FN_HIT && head.status == crbt_pkg::ST_OK)
                    state_next = crbt_pkg::BK_READ;
            crbt_pkg::BK_READ:
                state_next = crbt_pkg::BK_WRITE;
            crbt_pkg::BK_WRITE:
                if (!ov_reg || out_ready)
                    state_next = crbt_pkg::BK_RUN;
            default:
                state_next = crbt_pkg::BK_RUN;
        endcase
    end

    always_comb
    begin
        rd_en = 1'b0;
        emit  = 1'b0;
        wr_en = 1'b0;
        case (state_reg)
            crbt_pkg::BK_RUN:
            begin
                rd_en = (state_next == crbt_pkg::BK_READ);
                emit  = cnt_reg != '0 && (!ov_reg || out_ready) && !rd_en;
            end
            crbt_pkg::BK_WRITE:
            begin
                emit  = (!ov_reg || out_ready);
                wr_en = emit && ((rd_reg & bitm) == '0);
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end
    assign pop = emit;

    always_comb
    begin
        res                      = '0;
        res.done_func            = head.func;
        res.status               = head.status;
        res.found_slot           = head.slot;
        res.is_new               = wr_en;
        res.hit_count            = head.hit_count;
        res.total_count          = head.total_count;
        res.region_count         = head.region_count;
        res.covered_region_count = head.covered_region_count;
        if (head.func == crbt_pkg::FN_FINISH)
            res.new_count = newc_reg;
        wdata = rd_reg | bitm;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= crbt_pkg::BK_CLEAR;
            clr_reg   <= '0;
            wp_reg    <= 1'b0;
            rp_reg    <= 1'b0;
            cnt_reg   <= '0;
            newc_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == crbt_pkg::BK_CLEAR)
                clr_reg <= clr_reg + 1'b1;
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
            if (pop && head.func == crbt_pkg::FN_FINISH)
                newc_reg <= '0;
            else if (wr_en)
                newc_reg <= crbt_pkg::sat_inc(newc_reg);
            if (emit)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wp_reg] <= job;
        if (emit)
            od_reg <= res;
        if (rd_en)
            rd_reg <= mem[addr];
        if (state_reg == crbt_pkg::BK_CLEAR)
            mem[clr_reg] <= '0;
        else if (wr_en)
            mem[addr] <= wdata;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'd2)
        else $error("queue overfilled");
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> state_reg == crbt_pkg::BK_WRITE && head.status == crbt_pkg::ST_OK)
        else $error("bitmap write outside a hit");
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == crbt_pkg::BK_READ |=> state_reg == crbt_pkg::BK_WRITE)
        else $error("read not followed by write");

endmodule

### rtl/core/coverage_region_bitmap_tracker.sv
// Top level of the coverage region bitmap tracker: front classifier and back
// bitmap engine joined by a two-entry queue. Depends on crbt_pkg, crbt_front, crbt_back.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid / in_ready    | crbt_pkg::in_item_t
//   out     | output    | out_valid / out_ready  | crbt_pkg::out_item_t
//
// Every item passes the registered stage 1 of the front part; a hit that
// reaches the bitmap adds a registered read (READ state) and a WRITE state in the back.
// After reset all 8192 bitmap words are swept clear; requests queue
// meanwhile. Either side may stall; the queue and output register absorb it.
`timescale 1ns / 1ps
module coverage_region_bitmap_tracker
(
    input  logic                clk,
    input  logic                rst_n,
    input  crbt_pkg::in_item_t  in_data,
    input  logic                in_valid,
    output logic                in_ready,
    output crbt_pkg::out_item_t out_data,
    output logic                out_valid,
    input  logic                out_ready
);

    crbt_pkg::job_t job;
    logic           job_valid, job_ready;

    crbt_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .job       (job),
        .job_valid (job_valid),
        .job_ready (job_ready)
    );

    crbt_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );

endmodule
